[hdl/srsw_pkg.sv]
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the sender window
// Sizes, field widths, operation and status codes, and ring index helpers.
// ----------------------------------------------------------------------------
package srsw_pkg;

	// Window geometry and sequence number width.
	localparam int WINDOW_DEPTH = 16;
	localparam int SEQ_BITS     = 8;

	// Fixed field widths of the words on the ports.
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int SEQF_W = 8;
	localparam int TAG_W  = 16;
	localparam int CFG_W  = 5;
	localparam int CNTF_W = 5;

	// Derived widths.
	localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W  = IDX_W + 1;
	localparam int OCC_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int DIST_W = (SEQ_BITS > OCC_W) ? SEQ_BITS : OCC_W;
	localparam int SEQW_W = (SEQ_BITS > SEQF_W) ? SEQ_BITS : SEQF_W;

	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(4);

	// Operation codes of a command word.
	typedef enum logic [OP_W-1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	// Status codes of a result word.
	typedef enum logic [ST_W-1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_ACK_MISS = 2'd2,
		ST_TO_MISS  = 2'd3
	} status_t;

	// One ring entry as held in the entry RAM.
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             waiting;
	} entry_t;

	// One result word from the core to the output register.
	typedef struct packed {
		status_t           status;
		logic [SEQF_W-1:0] assigned_seq;
		logic              stop_timer;
		logic              start_timer;
		logic [SEQF_W-1:0] timer_seq;
		logic              resend;
		logic [TAG_W-1:0]  resend_tag;
		logic              window_full;
		logic [CNTF_W-1:0] waiting_count;
		logic [SEQF_W-1:0] base_seq_out;
	} result_t;

	// Ring index of a head plus an offset below twice the depth.
	function automatic logic [IDX_W-1:0] slot_wrap(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] r;
		r = sum;
		if (sum >= SUM_W'(WINDOW_DEPTH)) begin
			r = sum - SUM_W'(WINDOW_DEPTH);
		end
		return r[IDX_W-1:0];
	endfunction

	// Effective window limit: the register value capped at the depth.
	function automatic logic [CMP_W-1:0] window_limit(input logic [CFG_W-1:0] size);
		logic [CMP_W-1:0] r;
		r = CMP_W'(size);
		if (r > CMP_W'(WINDOW_DEPTH)) begin
			r = CMP_W'(WINDOW_DEPTH);
		end
		return r;
	endfunction

endpackage

[hdl/srsw_if.sv]
// ----------------------------------------------------------------------------
// srsw_if: handshake channels of the sender window
// Command, result and configuration channels with source and sink modports.
// ----------------------------------------------------------------------------

// Command channel: one word per send, ack or timeout.
interface srsw_cmd_if;
	import srsw_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SEQF_W-1:0] seq_number;
	logic [TAG_W-1:0]  packet_tag;
	modport source(output valid, operation, seq_number, packet_tag, input ready);
	modport sink(input valid, operation, seq_number, packet_tag, output ready);
endinterface

// Result channel: one word per command.
interface srsw_res_if;
	import srsw_pkg::*;
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [SEQF_W-1:0] assigned_seq;
	logic              stop_timer;
	logic              start_timer;
	logic [SEQF_W-1:0] timer_seq;
	logic              resend;
	logic [TAG_W-1:0]  resend_tag;
	logic              window_full;
	logic [CNTF_W-1:0] waiting_count;
	logic [SEQF_W-1:0] base_seq_out;
	modport source(output valid, status, assigned_seq, stop_timer, start_timer, timer_seq,
		resend, resend_tag, window_full, waiting_count, base_seq_out, input ready);
	modport sink(input valid, status, assigned_seq, stop_timer, start_timer, timer_seq,
		resend, resend_tag, window_full, waiting_count, base_seq_out, output ready);
endinterface

// Configuration channel: writes the window size register.
interface srsw_cfg_if;
	import srsw_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] window_size;
	modport source(output valid, window_size, input ready);
	modport sink(input valid, window_size, output ready);
endinterface

[hdl/selective_repeat_sender_window_top.sv]
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top: selective-repeat sender window
// Entry RAM, window sequencer, window size register and output register.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns one result word for
// it. Every command is decoded first; a matched ack or timeout then reads its
// entry from the RAM, and every ack then slides the window, the single read
// port of the entry RAM walking the ring one entry a cycle past the acked
// entries at the head, up to WINDOW_DEPTH of them. A new command is taken
// once the previous result has moved into the output register, so the output
// may be held while the next command is already at work. Entry flags are only
// read for occupied entries, so no clearing pass runs after reset.
module selective_repeat_sender_window_top (
	input logic      clk,
	input logic      arst_n,
	srsw_cmd_if.sink cmd,
	srsw_res_if.source res,
	srsw_cfg_if.sink cfg
);
	import srsw_pkg::*;

	logic [CFG_W-1:0] window_size_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             rslt_valid;
	logic             rslt_ready;
	result_t          rslt;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	// Entry RAM: packet tag and waiting flag of each ring slot.
	srsw_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Window sequencer.
	srsw_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.window_size(window_size_q),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// Window size register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			window_size_q <= cfg.window_size;
		end
	end

	// Output register between the sequencer and the result channel.
	assign rslt_ready = !out_valid_q || res.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_ready) begin
			out_valid_q <= rslt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_ready && rslt_valid) begin
			out_q <= rslt;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.assigned_seq  = out_q.assigned_seq;
	assign res.stop_timer    = out_q.stop_timer;
	assign res.start_timer   = out_q.start_timer;
	assign res.timer_seq     = out_q.timer_seq;
	assign res.resend        = out_q.resend;
	assign res.resend_tag    = out_q.resend_tag;
	assign res.window_full   = out_q.window_full;
	assign res.waiting_count = out_q.waiting_count;
	assign res.base_seq_out  = out_q.base_seq_out;

`ifndef ASSERT_OFF
	// A refused send leaves the window full.
	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == ST_FULL) |-> res.window_full)
		else $error("send refused while window not full");

	// A resend always comes with a timer restart.
	a_resend_timer: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.resend |-> res.start_timer && res.stop_timer)
		else $error("resend without timer restart");

	// The waiting count never exceeds the window depth.
	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.waiting_count <= CNTF_W'(WINDOW_DEPTH)))
		else $error("waiting count above window depth");

	// An accepted command keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while busy");
`endif

endmodule

[hdl/srsw_ram.sv]
// ----------------------------------------------------------------------------
// srsw_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/srsw_core.sv]
// ----------------------------------------------------------------------------
// srsw_core: window sequencer
// Holds the ring pointers and counters, and walks the entry RAM to append,
// match, clear and slide entries. One command is handled at a time.
// ----------------------------------------------------------------------------
module srsw_core (
	input  logic                                clk,
	input  logic                                arst_n,
	srsw_cmd_if.sink                            cmd,
	input  logic [srsw_pkg::CFG_W-1:0]          window_size,
	output logic                                rslt_valid,
	input  logic                                rslt_ready,
	output srsw_pkg::result_t                   rslt,
	output logic                                ram_we,
	output logic [srsw_pkg::IDX_W-1:0]          ram_waddr,
	output srsw_pkg::entry_t                    ram_wdata,
	output logic                                ram_re,
	output logic [srsw_pkg::IDX_W-1:0]          ram_raddr,
	input  srsw_pkg::entry_t                    ram_rdata
);
	import srsw_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE       = 6'b000001,
		S_DECODE     = 6'b000010,
		S_MATCH      = 6'b000100,
		S_SLIDE      = 6'b001000,
		S_SLIDE_WAIT = 6'b010000,
		S_FINISH     = 6'b100000
	} state_t;

	state_t state_q;

	// Window state.
	logic [IDX_W-1:0]    head_q;
	logic [OCC_W-1:0]    occ_q;
	logic [OCC_W-1:0]    wait_cnt_q;
	logic [SEQ_BITS-1:0] base_q;
	logic [SEQ_BITS-1:0] next_q;

	// Command word under work and the matched slot.
	logic [OP_W-1:0]   op_q;
	logic [SEQF_W-1:0] seq_q;
	logic [TAG_W-1:0]  tag_q;
	logic [IDX_W-1:0]  slot_q;

	// Per-command result fields.
	status_t           status_q;
	logic [SEQF_W-1:0] assigned_q;
	logic              stop_q;
	logic              start_q;
	logic [SEQF_W-1:0] tseq_q;
	logic              resend_q;
	logic [TAG_W-1:0]  rtag_q;

	logic              cmd_fire;
	logic              full;
	logic [SEQW_W-1:0] seq_wide;
	logic              seq_ok;
	logic [SEQ_BITS-1:0] seq_offset;
	logic              hit;
	logic [IDX_W-1:0]  append_slot;
	logic [IDX_W-1:0]  hit_slot;
	logic [IDX_W-1:0]  head_next;
	logic              pop;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Occupied entries carry consecutive sequence numbers from the base, so the
	// first entry holding a number sits at its distance from the base.
	assign full        = CMP_W'(occ_q) >= window_limit(window_size);
	assign seq_wide    = SEQW_W'(seq_q);
	assign seq_ok      = (seq_wide >> SEQ_BITS) == '0;
	assign seq_offset  = SEQ_BITS'(seq_wide) - base_q;
	assign hit         = seq_ok && (DIST_W'(seq_offset) < DIST_W'(occ_q));
	assign append_slot = slot_wrap(SUM_W'(head_q) + SUM_W'(occ_q));
	assign hit_slot    = slot_wrap(SUM_W'(head_q) + SUM_W'(seq_offset));
	assign head_next   = slot_wrap(SUM_W'(head_q) + SUM_W'(1));
	assign pop         = (state_q == S_SLIDE_WAIT) && !ram_rdata.waiting;

	// RAM accesses. A write and a read of the same entry never fall in the same
	// cycle: the ack clear is written in the cycle before the slide reads the head.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = append_slot;
		ram_wdata = '{tag: tag_q, waiting: 1'b1};
		ram_re    = 1'b0;
		ram_raddr = head_q;
		case (state_q)
			S_DECODE: begin
				if (op_q == OP_SEND) begin
					ram_we = !full;
				end else if ((op_q == OP_ACK || op_q == OP_TIMEOUT) && hit) begin
					ram_re    = 1'b1;
					ram_raddr = hit_slot;
				end
			end
			S_MATCH: begin
				ram_waddr = slot_q;
				ram_wdata = '{tag: ram_rdata.tag, waiting: 1'b0};
				ram_we    = (op_q == OP_ACK) && ram_rdata.waiting;
			end
			S_SLIDE: begin
				ram_re = (occ_q != '0);
			end
			S_SLIDE_WAIT: begin
				ram_raddr = head_next;
				ram_re    = pop && (occ_q > OCC_W'(1));
			end
			default: begin
			end
		endcase
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			occ_q      <= '0;
			wait_cnt_q <= '0;
			base_q     <= '0;
			next_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (op_q)
						OP_SEND: begin
							if (!full) begin
								occ_q      <= occ_q + OCC_W'(1);
								wait_cnt_q <= wait_cnt_q + OCC_W'(1);
								next_q     <= next_q + SEQ_BITS'(1);
							end
							state_q <= S_FINISH;
						end
						OP_ACK: begin
							state_q <= hit ? S_MATCH : S_SLIDE;
						end
						OP_TIMEOUT: begin
							state_q <= hit ? S_MATCH : S_FINISH;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_MATCH: begin
					if (op_q == OP_ACK) begin
						if (ram_rdata.waiting) begin
							wait_cnt_q <= wait_cnt_q - OCC_W'(1);
						end
						state_q <= S_SLIDE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SLIDE: begin
					state_q <= (occ_q != '0) ? S_SLIDE_WAIT : S_FINISH;
				end
				S_SLIDE_WAIT: begin
					if (pop) begin
						head_q <= head_next;
						occ_q  <= occ_q - OCC_W'(1);
						base_q <= base_q + SEQ_BITS'(1);
						if (occ_q == OCC_W'(1)) begin
							state_q <= S_FINISH;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (rslt_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture and result fields.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q       <= cmd.operation;
			seq_q      <= cmd.seq_number;
			tag_q      <= cmd.packet_tag;
			status_q   <= ST_DONE;
			assigned_q <= '0;
			stop_q     <= 1'b0;
			start_q    <= 1'b0;
			tseq_q     <= '0;
			resend_q   <= 1'b0;
			rtag_q     <= '0;
		end
		if (state_q == S_DECODE) begin
			slot_q <= hit_slot;
			case (op_q)
				OP_SEND: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						assigned_q <= SEQF_W'(next_q);
					end
				end
				OP_ACK: begin
					if (!hit) begin
						status_q <= ST_ACK_MISS;
					end
				end
				OP_TIMEOUT: begin
					if (!hit) begin
						status_q <= ST_TO_MISS;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_MATCH) begin
			stop_q <= 1'b1;
			tseq_q <= seq_q;
			if (op_q == OP_TIMEOUT) begin
				start_q  <= 1'b1;
				resend_q <= 1'b1;
				rtag_q   <= ram_rdata.tag;
			end
		end
	end

	// Result word, offered once the command is finished.
	assign rslt_valid = (state_q == S_FINISH);
	always_comb begin
		rslt.status        = status_q;
		rslt.assigned_seq  = assigned_q;
		rslt.stop_timer    = stop_q;
		rslt.start_timer   = start_q;
		rslt.timer_seq     = tseq_q;
		rslt.resend        = resend_q;
		rslt.resend_tag    = rtag_q;
		rslt.window_full   = full;
		rslt.waiting_count = CNTF_W'(wait_cnt_q);
		rslt.base_seq_out  = SEQF_W'(base_q);
	end

endmodule

[verif/tb_selective_repeat_sender_window_top.sv]
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window_top: testbench of the sender window
// Sends, acks and timeouts are driven at random pace against a model of the
// window ring that predicts every result word. Random acks and timeouts
// mostly name sequence numbers that are in flight. The window size register
// is stepped through its extremes and a spread of values in between.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window_top;
	timeunit 1ns;
	timeprecision 1ps;
	import srsw_pkg::*;

	// Operation code that the block treats as a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 128;
	localparam int QUIET_PHASE = 7;

	// Model copy of the window: ring entries, pointers and the size register.
	typedef struct packed {
		logic [WINDOW_DEPTH-1:0][SEQF_W-1:0] seqs;
		logic [WINDOW_DEPTH-1:0][TAG_W-1:0]  tags;
		logic [WINDOW_DEPTH-1:0]             waiting;
		logic [IDX_W-1:0]                    head;
		logic [CNTF_W-1:0]                   count;
		logic [SEQF_W-1:0]                   base;
		logic [SEQF_W-1:0]                   next_seq;
		logic [CFG_W-1:0]                    size;
	} window_state_t;

	// One command word waiting to be driven.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SEQF_W-1:0] seq;
		logic [TAG_W-1:0]  tag;
	} cmd_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	srsw_cmd_if cmd_ch();
	srsw_res_if res_ch();
	srsw_cfg_if cfg_ch();

	selective_repeat_sender_window_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	window_state_t window_now;
	window_state_t plan;
	cmd_word_t cmd_backlog[$];
	result_t due_results[$];
	int unsigned cmds_queued = 0;
	int unsigned cmds_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit cmd_taken = 1'b0;
	bit cfg_taken = 1'b0;
	bit steady = 1'b0;

	always #5 clk = ~clk;

	// Advance the window by one command word and return its result word.
	function automatic result_t window_step(inout window_state_t w,
		input logic [OP_W-1:0] op, input logic [SEQF_W-1:0] seq,
		input logic [TAG_W-1:0] tag);
		result_t r;
		int cap;
		int hit;
		int pos;
		int tally;
		int i;
		r = '0;
		cap = (w.size > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(w.size);
		// First occupied entry carrying this sequence number, flag ignored.
		hit = -1;
		for (i = 0; i < w.count; i++) begin
			pos = (w.head + i) % WINDOW_DEPTH;
			if (hit < 0 && w.seqs[pos] == seq) begin
				hit = pos;
			end
		end
		case (op)
			OP_SEND: begin
				if (w.count >= cap) begin
					r.status = ST_FULL;
				end else begin
					pos = (w.head + w.count) % WINDOW_DEPTH;
					w.seqs[pos] = w.next_seq;
					w.tags[pos] = tag;
					w.waiting[pos] = 1'b1;
					w.count = w.count + 1'b1;
					r.assigned_seq = w.next_seq;
					w.next_seq = w.next_seq + 1'b1;
				end
			end
			OP_ACK: begin
				if (hit < 0) begin
					r.status = ST_ACK_MISS;
				end else begin
					w.waiting[hit] = 1'b0;
					r.stop_timer = 1'b1;
					r.timer_seq = seq;
				end
				// Slide the base past every acknowledged entry at the head.
				while (w.count != 0 && !w.waiting[w.head]) begin
					w.head = IDX_W'((w.head + 1) % WINDOW_DEPTH);
					w.count = w.count - 1'b1;
					w.base = w.base + 1'b1;
				end
			end
			OP_TIMEOUT: begin
				if (hit < 0) begin
					r.status = ST_TO_MISS;
				end else begin
					r.stop_timer = 1'b1;
					r.start_timer = 1'b1;
					r.timer_seq = seq;
					r.resend = 1'b1;
					r.resend_tag = w.tags[hit];
				end
			end
			default: ;
		endcase
		tally = 0;
		for (i = 0; i < w.count; i++) begin
			if (w.waiting[(w.head + i) % WINDOW_DEPTH]) begin
				tally++;
			end
		end
		r.window_full = (w.count >= cap);
		r.waiting_count = CNTF_W'(tally);
		r.base_seq_out = w.base;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		end
	endfunction

	// Queue a command word and advance the planning copy of the window with it.
	task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [SEQF_W-1:0] seq,
		input logic [TAG_W-1:0] tag);
		cmd_backlog.push_back(cmd_word_t'{op, seq, tag});
		void'(window_step(plan, op, seq, tag));
		cmds_queued++;
	endtask

	// Wait until every queued word is accepted and every result has come back.
	task automatic drain();
		while (cmds_taken != cmds_queued || due_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_window(input logic [CFG_W-1:0] size);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.window_size <= size;
		do @(negedge clk); while (!cfg_taken);
		cfg_ch.valid <= 1'b0;
	endtask

	// Command driver and result stall, both at the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!cmd_ch.valid || cmd_taken)) begin
			if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.operation <= cmd_backlog[0].op;
				cmd_ch.seq_number <= cmd_backlog[0].seq;
				cmd_ch.packet_tag <= cmd_backlog[0].tag;
				void'(cmd_backlog.pop_front());
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
		res_ch.ready <= arst_n && (steady || $urandom_range(99) >= 30);
	end

	// Monitor: checks result words, then predicts for accepted command words.
	always @(posedge clk) begin : watch
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			cmd_taken = arst_n && cmd_ch.valid && cmd_ch.ready;
			cfg_taken = arst_n && cfg_ch.valid && cfg_ch.ready;
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected", $time);
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, res_ch.status);
					check_field("assigned_seq", want.assigned_seq, res_ch.assigned_seq);
					check_field("stop_timer", want.stop_timer, res_ch.stop_timer);
					check_field("start_timer", want.start_timer, res_ch.start_timer);
					check_field("timer_seq", want.timer_seq, res_ch.timer_seq);
					check_field("resend", want.resend, res_ch.resend);
					check_field("resend_tag", want.resend_tag, res_ch.resend_tag);
					check_field("window_full", want.window_full, res_ch.window_full);
					check_field("waiting_count", want.waiting_count, res_ch.waiting_count);
					check_field("base_seq_out", want.base_seq_out, res_ch.base_seq_out);
				end
			end
			if (cfg_taken) begin
				window_now.size = cfg_ch.window_size;
			end
			if (cmd_taken) begin
				want = window_step(window_now, cmd_ch.operation, cmd_ch.seq_number,
					cmd_ch.packet_tag);
				due_results.push_back(want);
				cmds_taken++;
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] sizes [PHASES];
		logic [SEQF_W-1:0] seq;
		int phase;
		int n;
		int pick;
		int pos;
		sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd16, 5'd5, 5'd12,
			5'd3, 5'd9};
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_SEND;
		cmd_ch.seq_number = '0;
		cmd_ch.packet_tag = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.window_size = '0;
		window_now = '0;
		window_now.size = WINDOW_SIZE_RESET;
		plan = window_now;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset window size of four.
		queue_cmd(OP_ACK, 8'h00, 16'h0000);
		queue_cmd(OP_TIMEOUT, 8'hFF, 16'hFFFF);
		queue_cmd(OP_UNUSED, 8'hFF, 16'hFFFF);
		queue_cmd(OP_SEND, 8'hFF, 16'h0000);
		queue_cmd(OP_SEND, 8'h00, 16'hFFFF);
		queue_cmd(OP_SEND, 8'hA5, 16'h5555);
		queue_cmd(OP_SEND, 8'h5A, 16'hAAAA);
		// Window now full: this send is refused.
		queue_cmd(OP_SEND, 8'h00, 16'h1234);
		queue_cmd(OP_TIMEOUT, 8'h02, 16'h0000);
		// Out-of-order ack, then the same entry acked and timed out again.
		queue_cmd(OP_ACK, 8'h01, 16'h0000);
		queue_cmd(OP_ACK, 8'h01, 16'h0000);
		queue_cmd(OP_TIMEOUT, 8'h01, 16'h0000);
		// Acking the head slides the base past both acked entries.
		queue_cmd(OP_ACK, 8'h00, 16'h0000);
		queue_cmd(OP_ACK, 8'h00, 16'h0000);
		queue_cmd(OP_TIMEOUT, 8'hAA, 16'h0000);
		queue_cmd(OP_SEND, 8'h00, 16'h0F0F);
		queue_cmd(OP_ACK, 8'h03, 16'h0000);
		queue_cmd(OP_ACK, 8'h02, 16'h0000);
		queue_cmd(OP_ACK, 8'h04, 16'h0000);
		queue_cmd(OP_UNUSED, 8'h00, 16'h0000);
		drain();

		// Random phases, each at its own window size; one runs without stalls.
		for (phase = 0; phase < PHASES; phase++) begin
			write_window(sizes[phase]);
			plan = window_now;
			steady = (phase == QUIET_PHASE);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				pos = (plan.head + $urandom_range(plan.count == 0 ? 0 : plan.count - 1))
					% WINDOW_DEPTH;
				seq = (plan.count == 0) ? SEQF_W'($urandom) : plan.seqs[pos];
				if (pick < 45) begin
					queue_cmd(OP_SEND, SEQF_W'($urandom), TAG_W'($urandom));
				end else if (pick < 75) begin
					queue_cmd(OP_ACK, seq, TAG_W'($urandom));
				end else if (pick < 88) begin
					queue_cmd(OP_TIMEOUT, seq, TAG_W'($urandom));
				end else if (pick < 96) begin
					queue_cmd(pick[0] ? OP_ACK : OP_TIMEOUT, SEQF_W'($urandom),
						TAG_W'($urandom));
				end else begin
					queue_cmd(OP_UNUSED, SEQF_W'($urandom), TAG_W'($urandom));
				end
			end
			drain();
		end
		steady = 1'b0;
		repeat (30) @(negedge clk);

		if (mismatches == 0 && due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/srsw_pkg.sv
hdl/srsw_if.sv
hdl/srsw_ram.sv
hdl/srsw_core.sv
hdl/selective_repeat_sender_window_top.sv
verif/tb_selective_repeat_sender_window_top.sv
